@@ design/hsv_rgb_brightness_pixel_unit_macros.svh @@
// Assertion macros shared by the checker of the pixel colour unit.
`ifndef HSV_RGB_BRIGHTNESS_PIXEL_UNIT_MACROS_SVH
`define HSV_RGB_BRIGHTNESS_PIXEL_UNIT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define HRBP_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The cause is followed by the effect a fixed number of cycles later.
`define HRBP_ASSERT_LAT(label, clk, rst_n, cause, lat, effect, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) \
    (cause) |-> ##lat (effect)) else $error(msg);

// The effect only appears when the cause was seen a fixed number of cycles earlier.
`define HRBP_ASSERT_PAST(label, clk, rst_n, effect, cause, lat, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) \
    (effect) |-> $past((cause), lat)) else $error(msg);

`endif

@@ design/hrbp_pkg.sv @@
// Types, constants and arithmetic helpers of the pixel colour unit.
`timescale 1ns / 1ps

package hrbp_pkg;

  // Configuration register indexes.
  localparam logic CFG_BRIGHTNESS = 1'b0;
  localparam logic CFG_ENABLE     = 1'b1;

  localparam logic [6:0] PCT_MAX   = 7'd100;
  localparam logic [7:0] BRI_RESET = 8'd255;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Exact floor(x / 255) for any x up to 255 * 255.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [15:0] sum;
    sum = x + {8'd0, x[15:8]} + 16'd1;
    return sum[15:8];
  endfunction

  // Percent (saturated at 100) to a 0..255 level: pct * 255 / 100, with the
  // division done as a multiplication by 5243 / 2^19.
  function automatic logic [7:0] bri_from_pct(input logic [6:0] pct);
    logic [6:0]  sat;
    logic [14:0] p255;
    logic [27:0] wide;
    sat  = (pct > PCT_MAX) ? PCT_MAX : pct;
    p255 = {sat, 8'd0} - {8'd0, sat};
    wide = {13'd0, p255} * 28'd5243;
    return wide[26:19];
  endfunction

endpackage

@@ design/hrbp_hsv.sv @@
// Five-stage HSV to RGB converter; direct RGB beats pass through alongside.
`timescale 1ns / 1ps

module hrbp_hsv (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic               req_type_i,
  input  logic [7:0]         hue_i,
  input  logic [7:0]         saturation_i,
  input  logic [7:0]         value_level_i,
  input  hrbp_pkg::rgb_t     rgb_i,
  output logic               valid_o,
  output hrbp_pkg::rgb_t     rgb_o
);

  typedef enum logic [2:0] {
    SEC_R_TO_Y = 3'd0,
    SEC_Y_TO_G = 3'd1,
    SEC_G_TO_C = 3'd2,
    SEC_C_TO_B = 3'd3,
    SEC_B_TO_M = 3'd4,
    SEC_M_TO_R = 3'd5
  } hue_sector_e;

  // Stage A: sector and scaled remainder.
  hue_sector_e    sec_d;
  logic [7:0]     base_d;
  logic [5:0]     diff_d;
  logic [7:0]     rem_d;

  logic           a_vld_q, a_hsv_q;
  hue_sector_e    a_sec_q;
  logic [7:0]     a_rem_q, a_s_q, a_v_q;
  hrbp_pkg::rgb_t a_rgb_q;

  // Stage B: first products.
  logic           b_vld_q, b_hsv_q;
  hue_sector_e    b_sec_q;
  logic [7:0]     b_v_q;
  logic [15:0]    b_vs_q, b_sr_q, b_st_q;
  hrbp_pkg::rgb_t b_rgb_q;

  // Stage C: first quotients.
  logic           c_vld_q, c_hsv_q;
  hue_sector_e    c_sec_q;
  logic [7:0]     c_v_q, c_p_q, c_qa_q, c_ta_q;
  hrbp_pkg::rgb_t c_rgb_q;

  // Stage D: second products.
  logic           d_vld_q, d_hsv_q;
  hue_sector_e    d_sec_q;
  logic [7:0]     d_v_q, d_p_q;
  logic [15:0]    d_vq_q, d_vt_q;
  hrbp_pkg::rgb_t d_rgb_q;

  // Stage E: channel selection.
  logic [7:0]     q_d, t_d;
  hrbp_pkg::rgb_t e_rgb_d;
  logic           e_vld_q;
  hrbp_pkg::rgb_t e_rgb_q;

  always_comb begin
    if (hue_i >= 8'd215) begin
      sec_d = SEC_M_TO_R;
    end else if (hue_i >= 8'd172) begin
      sec_d = SEC_B_TO_M;
    end else if (hue_i >= 8'd129) begin
      sec_d = SEC_C_TO_B;
    end else if (hue_i >= 8'd86) begin
      sec_d = SEC_G_TO_C;
    end else if (hue_i >= 8'd43) begin
      sec_d = SEC_Y_TO_G;
    end else begin
      sec_d = SEC_R_TO_Y;
    end
    case (sec_d)
      SEC_R_TO_Y: base_d = 8'd0;
      SEC_Y_TO_G: base_d = 8'd43;
      SEC_G_TO_C: base_d = 8'd86;
      SEC_C_TO_B: base_d = 8'd129;
      SEC_B_TO_M: base_d = 8'd172;
      default:    base_d = 8'd215;
    endcase
    diff_d = 6'(hue_i - base_d);
    rem_d  = {diff_d, 2'b00} + {1'b0, diff_d, 1'b0};
  end

  always_comb begin
    q_d = hrbp_pkg::div255(d_vq_q);
    t_d = hrbp_pkg::div255(d_vt_q);
    if (d_hsv_q) begin
      case (d_sec_q)
        SEC_R_TO_Y: e_rgb_d = '{red: d_v_q, green: t_d,   blue: d_p_q};
        SEC_Y_TO_G: e_rgb_d = '{red: q_d,   green: d_v_q, blue: d_p_q};
        SEC_G_TO_C: e_rgb_d = '{red: d_p_q, green: d_v_q, blue: t_d};
        SEC_C_TO_B: e_rgb_d = '{red: d_p_q, green: q_d,   blue: d_v_q};
        SEC_B_TO_M: e_rgb_d = '{red: t_d,   green: d_p_q, blue: d_v_q};
        default:    e_rgb_d = '{red: d_v_q, green: d_p_q, blue: q_d};
      endcase
    end else begin
      e_rgb_d = d_rgb_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
    end else begin
      a_vld_q <= valid_i;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
      e_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_hsv_q <= req_type_i;
    a_sec_q <= sec_d;
    a_rem_q <= rem_d;
    a_s_q   <= saturation_i;
    a_v_q   <= value_level_i;
    a_rgb_q <= rgb_i;

    // 255 - x on eight bits is the complement.
    b_hsv_q <= a_hsv_q;
    b_sec_q <= a_sec_q;
    b_v_q   <= a_v_q;
    b_vs_q  <= {8'd0, a_v_q} * {8'd0, ~a_s_q};
    b_sr_q  <= {8'd0, a_s_q} * {8'd0, a_rem_q};
    b_st_q  <= {8'd0, a_s_q} * {8'd0, ~a_rem_q};
    b_rgb_q <= a_rgb_q;

    c_hsv_q <= b_hsv_q;
    c_sec_q <= b_sec_q;
    c_v_q   <= b_v_q;
    c_p_q   <= hrbp_pkg::div255(b_vs_q);
    c_qa_q  <= hrbp_pkg::div255(b_sr_q);
    c_ta_q  <= hrbp_pkg::div255(b_st_q);
    c_rgb_q <= b_rgb_q;

    d_hsv_q <= c_hsv_q;
    d_sec_q <= c_sec_q;
    d_v_q   <= c_v_q;
    d_p_q   <= c_p_q;
    d_vq_q  <= {8'd0, c_v_q} * {8'd0, ~c_qa_q};
    d_vt_q  <= {8'd0, c_v_q} * {8'd0, ~c_ta_q};
    d_rgb_q <= c_rgb_q;

    e_rgb_q <= e_rgb_d;
  end

  assign valid_o = e_vld_q;
  assign rgb_o   = e_rgb_q;

endmodule

@@ design/hrbp_scale.sv @@
// Two-stage brightness scaler and GRB packer.
`timescale 1ns / 1ps

module hrbp_scale (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  hrbp_pkg::rgb_t rgb_i,
  input  logic [7:0]     bri_i,
  output logic           valid_o,
  output logic [23:0]    grb_o
);

  logic        f_vld_q;
  logic [15:0] f_r_q, f_g_q, f_b_q;
  logic        g_vld_q;
  logic [23:0] g_grb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
      g_vld_q <= 1'b0;
    end else begin
      f_vld_q <= valid_i;
      g_vld_q <= f_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f_r_q   <= {8'd0, rgb_i.red}   * {8'd0, bri_i};
    f_g_q   <= {8'd0, rgb_i.green} * {8'd0, bri_i};
    f_b_q   <= {8'd0, rgb_i.blue}  * {8'd0, bri_i};
    g_grb_q <= {hrbp_pkg::div255(f_g_q), hrbp_pkg::div255(f_r_q),
                hrbp_pkg::div255(f_b_q)};
  end

  assign valid_o = g_vld_q;
  assign grb_o   = g_grb_q;

endmodule

@@ design/hsv_rgb_brightness_pixel_unit.sv @@
// Pixel colour unit: HSV or RGB request to a brightness-scaled GRB word.
`timescale 1ns / 1ps

// A request is taken on every cycle that start_i is high; busy_o is never
// raised, so one pixel per clock is sustained. Each beat runs through seven
// register stages: five in the HSV converter (sector, products, quotients,
// second products, selection) and two in the brightness scaler; results
// appear on grb_word_o with done_o in request order. The receiver cannot
// stall and must take each beat in the single cycle done_o is high. While
// the enable register is clear a request is taken but gives no result.
// Register 0 sets brightness in percent (values above 100 count as 100),
// register 1 the enable; write them only when no request is in flight.
module hsv_rgb_brightness_pixel_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        req_type_i,
  input  logic [7:0]  hue_i,
  input  logic [7:0]  saturation_i,
  input  logic [7:0]  value_level_i,
  input  logic [7:0]  red_in_i,
  input  logic [7:0]  green_in_i,
  input  logic [7:0]  blue_in_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [6:0]  cfg_wdata_i,
  output logic        done_o,
  output logic [23:0] grb_word_o
);

  logic           bri_q;
  logic [7:0]     bri_lvl_q;
  logic           en_q;
  logic           hsv_vld;
  hrbp_pkg::rgb_t hsv_rgb;
  hrbp_pkg::rgb_t rgb_in;

  // The brightness level is worked out once per register write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bri_lvl_q <= hrbp_pkg::BRI_RESET;
      en_q      <= 1'b0;
      bri_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hrbp_pkg::CFG_BRIGHTNESS: begin
          bri_lvl_q <= hrbp_pkg::bri_from_pct(cfg_wdata_i);
          bri_q     <= 1'b1;
        end
        hrbp_pkg::CFG_ENABLE: en_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;
  assign rgb_in = '{red: red_in_i, green: green_in_i, blue: blue_in_i};

  hrbp_hsv u_hsv (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (start_i && !busy_o && en_q),
    .req_type_i    (req_type_i),
    .hue_i         (hue_i),
    .saturation_i  (saturation_i),
    .value_level_i (value_level_i),
    .rgb_i         (rgb_in),
    .valid_o       (hsv_vld),
    .rgb_o         (hsv_rgb)
  );

  hrbp_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (hsv_vld),
    .rgb_i   (hsv_rgb),
    .bri_i   (bri_q ? bri_lvl_q : hrbp_pkg::BRI_RESET),
    .valid_o (done_o),
    .grb_o   (grb_word_o)
  );

endmodule

@@ design/hrbp_checker.sv @@
// Port-level checker of the pixel colour unit and its bind.
`timescale 1ns / 1ps
`include "hsv_rgb_brightness_pixel_unit_macros.svh"

module hrbp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        cfg_we_i,
  input logic        cfg_idx_i,
  input logic [6:0]  cfg_wdata_i,
  input logic        done_o
);

  // Shadow of the enable register, as seen on the write port.
  logic en_q;
  logic req_acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= 1'b0;
    end else if (cfg_we_i && (cfg_idx_i == hrbp_pkg::CFG_ENABLE)) begin
      en_q <= cfg_wdata_i[0];
    end
  end

  // A request beat that is taken while the unit is enabled.
  assign req_acc = start_i && !busy_o && en_q;

  `HRBP_ASSERT_ALWAYS(a_never_busy, clk_i, rst_ni, !busy_o, "unit raised busy")
  `HRBP_ASSERT_LAT(a_beat_out, clk_i, rst_ni, req_acc, 7, done_o, "request beat lost")
  `HRBP_ASSERT_PAST(a_no_spurious, clk_i, rst_ni, done_o, req_acc, 7, "stray result beat")

endmodule

bind hsv_rgb_brightness_pixel_unit hrbp_checker u_hrbp_checker (.*);
